// ===== rtl/ini_tok_pkg.sv =====
// ============================================================================
// ini_tok_pkg
// Shared types and character codes for the INI text tokenizer.
// ============================================================================
package ini_tok_pkg;

    // Command carried in the input word's tuser
    typedef enum logic [1:0] {
        CMD_TEXT  = 2'd0,
        CMD_EOT   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Result status code
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_BEYOND   = 2'd2
    } status_t;

    // Parser phase
    typedef enum logic [3:0] {
        PH_LINE     = 4'd0,
        PH_COMMENT  = 4'd1,
        PH_SECTION  = 4'd2,
        PH_KEY_U    = 4'd3,
        PH_KEY_Q    = 4'd4,
        PH_KEY_QE   = 4'd5,
        PH_KEY_AQ   = 4'd6,
        PH_VAL_SKIP = 4'd7,
        PH_VAL_U    = 4'd8,
        PH_VAL_Q    = 4'd9,
        PH_VAL_QE   = 4'd10,
        PH_VAL_AQ   = 4'd11
    } phase_t;

    // Section terminator write sequencer
    typedef enum logic [1:0] {
        SEQ_IDLE  = 2'd0,
        SEQ_BREAK = 2'd1,
        SEQ_NUL   = 2'd2
    } seq_t;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

endpackage

// ===== rtl/ini_text_tokenizer_core.sv =====
// ============================================================================
// ini_text_tokenizer_core
// Streaming INI tokenizer that packs sections and settings into a byte store.
// ============================================================================
// Usage:
//   Input words arrive on s_tvalid/s_tready; s_tuser holds the command (text
//   byte, end of text, read stored byte, clear store) and s_tdata holds the
//   text byte and the read address. Every input word yields exactly one result
//   word on m_tvalid/m_tready: the stored byte for a read, the committed length
//   and a status code.
//   Results pass through a result stage and the output register. One word
//   is taken per cycle unless the output stalls; a section's closing bracket
//   holds input while its terminator bytes take the single store write port one per cycle.
//   Parser state lives in registers; packed bytes live in a synchronous store
//   with registered read data. Reads only touch committed bytes, which are
//   always written before the edge that accepts the read.
//   Reset clears pointers, phase and the overflow flag; store contents are
//   left as they are and only committed entries are ever read back.
//   When the receiver stalls, the output register and one result stage hold,
//   and s_tready drops once both are full.
// ============================================================================
module ini_text_tokenizer_core #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] text_byte, [19:8] read_address, [23:20] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] read_byte, [20:8] stored_length, [22:21] status
);

    localparam int PW = $clog2(STORE_DEPTH + 1);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = (PW > 12) ? PW : 12;
    localparam logic [PW:0] DEPTH_X = (PW+1)'(STORE_DEPTH);

    // Parser state
    logic [PW-1:0]            wp_reg, wp_next;
    logic [PW-1:0]            ls_reg, ls_next;
    logic [PW-1:0]            tp_reg, tp_next;
    logic                     te_reg, te_next;
    logic                     ovf_reg, ovf_next;
    ini_tok_pkg::phase_t      phase_reg, phase_next;

    // Section terminator sequencer
    ini_tok_pkg::seq_t        seq_reg, seq_next;
    logic [PW-1:0]            seq_ptr_reg, seq_ptr_next;
    logic                     seq_busy;
    logic                     seq_we;
    logic [7:0]               seq_data;

    // Result stage and output register
    logic                     s1_valid_reg;
    logic                     s1_rd_ok_reg;
    logic [12:0]              s1_len_reg;
    ini_tok_pkg::status_t     s1_status_reg;
    logic                     s1_adv;
    logic                     m_valid_reg;
    logic [23:0]              m_data_reg;

    // Input decode
    logic                     accept;
    ini_tok_pkg::cmd_t        cmd_in;
    logic [7:0]               byte_in;
    logic [11:0]              addr_in;
    logic                     is_text;
    logic                     is_eot;
    logic                     is_blank;
    logic                     is_break;
    logic                     rd_ok;
    ini_tok_pkg::status_t     status_next;

    // Put request
    logic                     put_req;
    logic                     put_three;
    logic [PW-1:0]            put_ptr;
    logic [7:0]               put_data;
    logic                     trim_after;
    logic                     commit_req;
    logic                     put_fail;
    logic [PW:0]              end_ptr;
    logic                     wr_go;
    ini_tok_pkg::phase_t      fail_phase;

    // Unquoted key helper inputs
    logic                     key_req;
    logic [PW-1:0]            key_wp;
    logic [PW-1:0]            key_tp;
    logic                     key_te;

    // Store ports
    logic                     mem_we;
    logic [AW-1:0]            mem_wa;
    logic [7:0]               mem_wd;
    logic [7:0]               mem_rd;
    logic                     len_over;

    assign cmd_in   = ini_tok_pkg::cmd_t'(s_tuser);
    assign byte_in  = s_tdata[7:0];
    assign addr_in  = s_tdata[19:8];
    assign accept   = s_tvalid && s_tready;
    assign is_text  = (cmd_in == ini_tok_pkg::CMD_TEXT) && (byte_in != ini_tok_pkg::CH_NUL);
    assign is_eot   = ((cmd_in == ini_tok_pkg::CMD_TEXT) && (byte_in == ini_tok_pkg::CH_NUL))
                   || (cmd_in == ini_tok_pkg::CMD_EOT);
    assign is_blank = (byte_in == ini_tok_pkg::CH_SPACE) || (byte_in == ini_tok_pkg::CH_TAB);
    assign is_break = (byte_in == ini_tok_pkg::CH_CR) || (byte_in == ini_tok_pkg::CH_LF);
    assign rd_ok    = (cmd_in == ini_tok_pkg::CMD_READ) && (CW'(addr_in) < CW'(ls_reg));

    // Advance the result stage when the output register frees up
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !seq_busy && (!s1_valid_reg || s1_adv);

    // Parser next state
    always_comb
    begin
        wp_next    = wp_reg;
        ls_next    = ls_reg;
        tp_next    = tp_reg;
        te_next    = te_reg;
        ovf_next   = ovf_reg;
        phase_next = phase_reg;
        put_req    = 1'b0;
        put_three  = 1'b0;
        put_ptr    = wp_reg;
        put_data   = byte_in;
        trim_after = 1'b0;
        commit_req = 1'b0;
        key_req    = 1'b0;
        key_wp     = wp_reg;
        key_tp     = tp_reg;
        key_te     = te_reg;
        fail_phase = ini_tok_pkg::PH_LINE;
        end_ptr    = '0;
        put_fail   = 1'b0;
        wr_go      = 1'b0;

        if (accept && is_text)
        begin
            fail_phase = is_break ? ini_tok_pkg::PH_LINE : ini_tok_pkg::PH_COMMENT;
            unique case (phase_reg)
                ini_tok_pkg::PH_LINE:
                begin
                    if (!is_blank && !is_break)
                    begin
                        wp_next = ls_reg;
                        tp_next = ls_reg;
                        te_next = 1'b1;
                        if (byte_in == ini_tok_pkg::CH_SEMI)
                            phase_next = ini_tok_pkg::PH_COMMENT;
                        else if (byte_in == ini_tok_pkg::CH_LBRACK)
                            phase_next = ini_tok_pkg::PH_SECTION;
                        else if (byte_in == ini_tok_pkg::CH_QUOTE)
                            phase_next = ini_tok_pkg::PH_KEY_Q;
                        else
                        begin
                            key_req = 1'b1;
                            key_wp  = ls_reg;
                            key_tp  = ls_reg;
                            key_te  = 1'b1;
                        end
                    end
                end
                ini_tok_pkg::PH_COMMENT:
                begin
                    if (is_break)
                        phase_next = ini_tok_pkg::PH_LINE;
                end
                ini_tok_pkg::PH_SECTION:
                begin
                    if (byte_in == ini_tok_pkg::CH_RBRACK)
                    begin
                        put_req    = 1'b1;
                        put_three  = 1'b1;
                        put_data   = ini_tok_pkg::CH_NUL;
                        commit_req = 1'b1;
                        phase_next = ini_tok_pkg::PH_LINE;
                    end
                    else if (is_break)
                    begin
                        wp_next    = ls_reg;
                        tp_next    = ls_reg;
                        te_next    = 1'b1;
                        phase_next = ini_tok_pkg::PH_LINE;
                    end
                    else
                        put_req = 1'b1;
                end
                ini_tok_pkg::PH_KEY_U:
                begin
                    key_req = 1'b1;
                end
                ini_tok_pkg::PH_KEY_Q, ini_tok_pkg::PH_VAL_Q:
                begin
                    if (byte_in == ini_tok_pkg::CH_QUOTE)
                    begin
                        put_req    = 1'b1;
                        put_data   = ini_tok_pkg::CH_NUL;
                        phase_next = (phase_reg == ini_tok_pkg::PH_KEY_Q)
                                   ? ini_tok_pkg::PH_KEY_AQ : ini_tok_pkg::PH_VAL_AQ;
                    end
                    else if (is_break)
                    begin
                        wp_next    = ls_reg;
                        tp_next    = ls_reg;
                        te_next    = 1'b1;
                        phase_next = ini_tok_pkg::PH_LINE;
                    end
                    else if (byte_in == ini_tok_pkg::CH_BSLASH)
                        phase_next = (phase_reg == ini_tok_pkg::PH_KEY_Q)
                                   ? ini_tok_pkg::PH_KEY_QE : ini_tok_pkg::PH_VAL_QE;
                    else
                    begin
                        put_req = 1'b1;
                        if (phase_reg == ini_tok_pkg::PH_KEY_Q)
                            te_next = 1'b0;
                    end
                end
                ini_tok_pkg::PH_KEY_QE:
                begin
                    put_req    = 1'b1;
                    te_next    = 1'b0;
                    phase_next = ini_tok_pkg::PH_KEY_Q;
                end
                ini_tok_pkg::PH_KEY_AQ:
                begin
                    if (!is_blank)
                    begin
                        if ((byte_in == ini_tok_pkg::CH_EQUAL) && !te_reg)
                            phase_next = ini_tok_pkg::PH_VAL_SKIP;
                        else
                        begin
                            wp_next    = ls_reg;
                            tp_next    = ls_reg;
                            te_next    = 1'b1;
                            phase_next = is_break ? ini_tok_pkg::PH_LINE
                                                  : ini_tok_pkg::PH_COMMENT;
                        end
                    end
                end
                ini_tok_pkg::PH_VAL_SKIP:
                begin
                    if (is_break)
                    begin
                        put_req    = 1'b1;
                        put_data   = ini_tok_pkg::CH_NUL;
                        commit_req = 1'b1;
                        phase_next = ini_tok_pkg::PH_LINE;
                    end
                    else if (byte_in == ini_tok_pkg::CH_QUOTE)
                        phase_next = ini_tok_pkg::PH_VAL_Q;
                    else if (!is_blank)
                    begin
                        put_req    = 1'b1;
                        trim_after = 1'b1;
                        phase_next = ini_tok_pkg::PH_VAL_U;
                    end
                end
                ini_tok_pkg::PH_VAL_U:
                begin
                    put_req = 1'b1;
                    if (is_break)
                    begin
                        put_ptr    = tp_reg;
                        put_data   = ini_tok_pkg::CH_NUL;
                        commit_req = 1'b1;
                        phase_next = ini_tok_pkg::PH_LINE;
                    end
                    else
                        trim_after = !is_blank;
                end
                ini_tok_pkg::PH_VAL_QE:
                begin
                    put_req    = 1'b1;
                    phase_next = ini_tok_pkg::PH_VAL_Q;
                end
                ini_tok_pkg::PH_VAL_AQ:
                begin
                    if (is_break)
                    begin
                        commit_req = 1'b1;
                        phase_next = ini_tok_pkg::PH_LINE;
                    end
                    else if (!is_blank)
                    begin
                        wp_next    = ls_reg;
                        tp_next    = ls_reg;
                        te_next    = 1'b1;
                        phase_next = ini_tok_pkg::PH_COMMENT;
                    end
                end
                default:
                begin
                    wp_next    = ls_reg;
                    tp_next    = ls_reg;
                    te_next    = 1'b1;
                    phase_next = ini_tok_pkg::PH_LINE;
                end
            endcase
        end
        else if (accept && is_eot)
        begin
            phase_next = ini_tok_pkg::PH_LINE;
            case (phase_reg)
                ini_tok_pkg::PH_VAL_SKIP, ini_tok_pkg::PH_VAL_Q, ini_tok_pkg::PH_VAL_QE:
                begin
                    put_req    = 1'b1;
                    put_data   = ini_tok_pkg::CH_NUL;
                    commit_req = 1'b1;
                end
                ini_tok_pkg::PH_VAL_U:
                begin
                    put_req    = 1'b1;
                    put_ptr    = tp_reg;
                    put_data   = ini_tok_pkg::CH_NUL;
                    commit_req = 1'b1;
                end
                ini_tok_pkg::PH_VAL_AQ:
                begin
                    commit_req = 1'b1;
                end
                default:
                begin
                    wp_next = ls_reg;
                    tp_next = ls_reg;
                    te_next = 1'b1;
                end
            endcase
        end
        else if (accept && (cmd_in == ini_tok_pkg::CMD_CLEAR))
        begin
            wp_next    = '0;
            ls_next    = '0;
            tp_next    = '0;
            te_next    = 1'b1;
            ovf_next   = 1'b0;
            phase_next = ini_tok_pkg::PH_LINE;
        end

        // Unquoted key byte
        if (key_req)
        begin
            if (is_break)
            begin
                wp_next    = ls_reg;
                tp_next    = ls_reg;
                te_next    = 1'b1;
                phase_next = ini_tok_pkg::PH_LINE;
            end
            else if (byte_in == ini_tok_pkg::CH_EQUAL)
            begin
                if (key_te)
                begin
                    wp_next    = ls_reg;
                    tp_next    = ls_reg;
                    te_next    = 1'b1;
                    phase_next = ini_tok_pkg::PH_COMMENT;
                end
                else
                begin
                    put_req    = 1'b1;
                    put_ptr    = key_tp;
                    put_data   = ini_tok_pkg::CH_NUL;
                    phase_next = ini_tok_pkg::PH_VAL_SKIP;
                end
            end
            else
            begin
                put_req    = 1'b1;
                put_ptr    = key_wp;
                phase_next = ini_tok_pkg::PH_KEY_U;
                if (!is_blank)
                begin
                    te_next    = 1'b0;
                    trim_after = 1'b1;
                end
            end
        end

        // Resolve the store write against capacity
        if (put_req)
        begin
            end_ptr = {1'b0, put_ptr} + (put_three ? (PW+1)'(3) : (PW+1)'(1));
            if (end_ptr > DEPTH_X)
                put_fail = 1'b1;
            else
            begin
                wr_go   = 1'b1;
                wp_next = end_ptr[PW-1:0];
                if (trim_after)
                    tp_next = end_ptr[PW-1:0];
            end
        end

        // Commit the finished item
        if (commit_req)
        begin
            if (!put_fail)
                ls_next = wp_next;
            tp_next = ls_next;
            te_next = 1'b1;
        end

        // Roll back on a full store
        if (put_fail)
        begin
            ovf_next   = 1'b1;
            wp_next    = ls_reg;
            tp_next    = ls_reg;
            te_next    = 1'b1;
            phase_next = fail_phase;
        end
    end

    // Sequencer next state
    always_comb
    begin
        seq_next     = seq_reg;
        seq_ptr_next = seq_ptr_reg;
        unique case (seq_reg)
            ini_tok_pkg::SEQ_IDLE:
            begin
                if (wr_go && put_three)
                begin
                    seq_next     = ini_tok_pkg::SEQ_BREAK;
                    seq_ptr_next = put_ptr + PW'(1);
                end
            end
            ini_tok_pkg::SEQ_BREAK:
            begin
                seq_next     = ini_tok_pkg::SEQ_NUL;
                seq_ptr_next = seq_ptr_reg + PW'(1);
            end
            ini_tok_pkg::SEQ_NUL:
            begin
                seq_next = ini_tok_pkg::SEQ_IDLE;
            end
            default:
            begin
                seq_next = ini_tok_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        seq_busy = 1'b0;
        seq_we   = 1'b0;
        seq_data = ini_tok_pkg::CH_NUL;
        unique case (seq_reg)
            ini_tok_pkg::SEQ_IDLE:
            begin
                seq_busy = 1'b0;
            end
            ini_tok_pkg::SEQ_BREAK:
            begin
                seq_busy = 1'b1;
                seq_we   = 1'b1;
                seq_data = ini_tok_pkg::CH_LF;
            end
            ini_tok_pkg::SEQ_NUL:
            begin
                seq_busy = 1'b1;
                seq_we   = 1'b1;
                seq_data = ini_tok_pkg::CH_NUL;
            end
            default:
            begin
                seq_busy = 1'b1;
            end
        endcase
    end

    // Store write port: parser byte or terminator byte
    assign mem_we = wr_go || seq_we;
    assign mem_wa = seq_we ? AW'(seq_ptr_reg) : AW'(put_ptr);
    assign mem_wd = seq_we ? seq_data : (put_three ? ini_tok_pkg::CH_NUL : put_data);

    assign status_next = ((cmd_in == ini_tok_pkg::CMD_READ) && !rd_ok) ? ini_tok_pkg::ST_BEYOND
                       : (ovf_next ? ini_tok_pkg::ST_OVERFLOW : ini_tok_pkg::ST_OK);

    ini_tok_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_en   (accept && rd_ok),
        .rd_addr (AW'(addr_in)),
        .rd_data (mem_rd)
    );

    ini_tok_core_assertions_placeholder #(
        .DEPTH (STORE_DEPTH)
    ) u_len_chk (
        .length (ls_reg),
        .over   (len_over)
    );

    // Hold parser and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            ls_reg      <= '0;
            tp_reg      <= '0;
            te_reg      <= 1'b1;
            ovf_reg     <= 1'b0;
            phase_reg   <= ini_tok_pkg::PH_LINE;
            seq_reg     <= ini_tok_pkg::SEQ_IDLE;
            seq_ptr_reg <= '0;
        end
        else
        begin
            wp_reg      <= wp_next;
            ls_reg      <= ls_next;
            tp_reg      <= tp_next;
            te_reg      <= te_next;
            ovf_reg     <= ovf_next;
            phase_reg   <= phase_next;
            seq_reg     <= seq_next;
            seq_ptr_reg <= seq_ptr_next;
        end
    end

    // Result stage valid and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Result stage and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_ok_reg  <= rd_ok;
            s1_len_reg    <= 13'(ls_next);
            s1_status_reg <= status_next;
        end
        if (s1_adv)
        begin
            m_data_reg <= {1'b0, s1_status_reg, s1_len_reg,
                           (s1_rd_ok_reg ? mem_rd : 8'h00)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    // Pointers stay ordered and within the store
    a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ls_reg <= tp_reg) && (tp_reg <= wp_reg) && !len_over)
        else $error("pointer order broken");

    // No word is taken while terminator bytes are still being written
    a_seq_block: assert property (@(posedge clk) disable iff (!rst_n)
        seq_busy |-> !s_tready)
        else $error("input accepted during terminator write");

    // A section close always runs the full terminator sequence
    a_seq_run: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == ini_tok_pkg::SEQ_BREAK) |=> (seq_reg == ini_tok_pkg::SEQ_NUL))
        else $error("terminator sequence cut short");

    // A read beyond the committed length returns a zero byte
    a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[22:21] == ini_tok_pkg::ST_BEYOND)) |-> (m_tdata[7:0] == 8'h00))
        else $error("nonzero byte on out-of-range read");
`endif

endmodule

// ===== rtl/ini_tok_store.sv =====
// ============================================================================
// ini_tok_store
// Packed byte store: one write port, one read port, registered read data.
// ============================================================================
module ini_tok_store #(
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write a byte and capture read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ini_tok_core_assertions_placeholder.sv =====
// ============================================================================
// ini_tok_core_assertions_placeholder
// Commit length probe: flags a committed length beyond the store depth.
// ============================================================================
module ini_tok_core_assertions_placeholder #(
    parameter int DEPTH = 4096
) (
    input  logic [$clog2(DEPTH+1)-1:0] length,
    output logic                       over
);

    // Compare committed length against capacity
    assign over = ({1'b0, length} > ($clog2(DEPTH+1)+1)'(DEPTH));

endmodule

// ===== sim/ini_text_tokenizer_core_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ini_text_tokenizer_core_tb
// Self-checking bench for the streaming INI tokenizer. A driver feeds text,
// end-of-text, read and clear words with random gaps. A receiver stalls at
// random. Every accepted word runs through a local copy of the tokenizer
// state, and each result word is checked against the oldest predicted one.
// The stimulus covers well-formed sections and settings, malformed lines,
// noise, and a pass that fills the byte store to its limit.
// ============================================================================
module ini_text_tokenizer_core_tb;

    import ini_tok_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int CYCLE_LIMIT = 1_200_000;
    localparam int MAX_REPORTS = 100;

    // One word queued for the driver, or a marker that waits for all results
    typedef struct {
        cmd_t        cmd;
        logic [7:0]  text;
        logic [11:0] addr;
        bit          pick;   // choose a committed address when sent
        bit          drain;
        int unsigned gap;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  rd;
        logic [12:0] len;
        status_t     st;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    in_word_t    text_feed[$];
    result_t     predicted_out[$];
    logic [7:0]  line_buf[$];

    bit          in_taken;
    bit          out_taken;
    bit          tx_calm;
    bit          rx_calm;
    int unsigned tx_wait;
    int unsigned rx_wait;
    int unsigned n_cycles;
    int unsigned n_queued;
    int unsigned n_words;
    int unsigned n_checked;
    int unsigned n_reads;
    int unsigned n_clears;
    int unsigned n_seals;
    int unsigned n_full;
    int unsigned n_errors;

    // Local copy of the tokenizer state
    logic [7:0]  shadow_mem [STORE_DEPTH];
    int unsigned wr_ptr;
    int unsigned commit_ptr;
    int unsigned trim_ptr;
    phase_t      phase;
    bit          tok_empty;
    bit          ovf;
    bit          wfail;

    ini_text_tokenizer_core #(
        .STORE_DEPTH (STORE_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Tokenizer prediction
    // ------------------------------------------------------------------------
    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB;
    endfunction

    function automatic bit is_break(logic [7:0] b);
        return b == CH_CR || b == CH_LF;
    endfunction

    function automatic void mem_put(logic [7:0] b);
        if (wr_ptr >= STORE_DEPTH)
        begin
            ovf   = 1'b1;
            wfail = 1'b1;
        end
        else
        begin
            shadow_mem[wr_ptr] = b;
            wr_ptr++;
        end
    endfunction

    function automatic void drop_line();
        wr_ptr    = commit_ptr;
        trim_ptr  = commit_ptr;
        tok_empty = 1'b1;
    endfunction

    function automatic void seal_line();
        if (!wfail)
        begin
            commit_ptr = wr_ptr;
            n_seals++;
        end
        trim_ptr  = commit_ptr;
        tok_empty = 1'b1;
    endfunction

    function automatic void key_plain(logic [7:0] b);
        if (is_break(b))
        begin
            drop_line();
            phase = PH_LINE;
        end
        else if (b == CH_EQUAL)
        begin
            if (tok_empty)
            begin
                drop_line();
                phase = PH_COMMENT;
            end
            else
            begin
                wr_ptr = trim_ptr;
                mem_put(CH_NUL);
                phase = PH_VAL_SKIP;
            end
        end
        else
        begin
            mem_put(b);
            if (!is_blank(b))
            begin
                tok_empty = 1'b0;
                trim_ptr  = wr_ptr;
            end
            phase = PH_KEY_U;
        end
    endfunction

    function automatic void val_plain(logic [7:0] b);
        if (is_break(b))
        begin
            wr_ptr = trim_ptr;
            mem_put(CH_NUL);
            seal_line();
            phase = PH_LINE;
        end
        else
        begin
            mem_put(b);
            if (!is_blank(b))
                trim_ptr = wr_ptr;
            phase = PH_VAL_U;
        end
    endfunction

    function automatic void take_text(logic [7:0] b);
        case (phase)
            PH_LINE:
            begin
                if (!is_blank(b) && !is_break(b))
                begin
                    drop_line();
                    if (b == CH_SEMI)
                        phase = PH_COMMENT;
                    else if (b == CH_LBRACK)
                        phase = PH_SECTION;
                    else if (b == CH_QUOTE)
                        phase = PH_KEY_Q;
                    else
                        key_plain(b);
                end
            end
            PH_COMMENT:
                if (is_break(b))
                    phase = PH_LINE;
            PH_SECTION:
            begin
                if (b == CH_RBRACK)
                begin
                    mem_put(CH_NUL);
                    mem_put(CH_LF);
                    mem_put(CH_NUL);
                    seal_line();
                    phase = PH_LINE;
                end
                else if (is_break(b))
                begin
                    drop_line();
                    phase = PH_LINE;
                end
                else
                    mem_put(b);
            end
            PH_KEY_U:
                key_plain(b);
            PH_KEY_Q:
            begin
                if (b == CH_QUOTE)
                begin
                    mem_put(CH_NUL);
                    phase = PH_KEY_AQ;
                end
                else if (is_break(b))
                begin
                    drop_line();
                    phase = PH_LINE;
                end
                else if (b == CH_BSLASH)
                    phase = PH_KEY_QE;
                else
                begin
                    mem_put(b);
                    tok_empty = 1'b0;
                end
            end
            PH_KEY_QE:
            begin
                mem_put(b);
                tok_empty = 1'b0;
                phase     = PH_KEY_Q;
            end
            PH_KEY_AQ:
            begin
                if (!is_blank(b))
                begin
                    if (b == CH_EQUAL && !tok_empty)
                        phase = PH_VAL_SKIP;
                    else
                    begin
                        drop_line();
                        phase = is_break(b) ? PH_LINE : PH_COMMENT;
                    end
                end
            end
            PH_VAL_SKIP:
            begin
                if (is_break(b))
                begin
                    mem_put(CH_NUL);
                    seal_line();
                    phase = PH_LINE;
                end
                else if (b == CH_QUOTE)
                    phase = PH_VAL_Q;
                else if (!is_blank(b))
                begin
                    trim_ptr = wr_ptr;
                    val_plain(b);
                end
            end
            PH_VAL_U:
                val_plain(b);
            PH_VAL_Q:
            begin
                if (b == CH_QUOTE)
                begin
                    mem_put(CH_NUL);
                    phase = PH_VAL_AQ;
                end
                else if (is_break(b))
                begin
                    drop_line();
                    phase = PH_LINE;
                end
                else if (b == CH_BSLASH)
                    phase = PH_VAL_QE;
                else
                    mem_put(b);
            end
            PH_VAL_QE:
            begin
                mem_put(b);
                phase = PH_VAL_Q;
            end
            PH_VAL_AQ:
            begin
                if (is_break(b))
                begin
                    seal_line();
                    phase = PH_LINE;
                end
                else if (!is_blank(b))
                begin
                    drop_line();
                    phase = PH_COMMENT;
                end
            end
            default:
            begin
                drop_line();
                phase = PH_LINE;
            end
        endcase
    endfunction

    // Close an open value at end of text; anything else is dropped
    function automatic void take_end();
        case (phase)
            PH_VAL_SKIP, PH_VAL_Q, PH_VAL_QE:
            begin
                mem_put(CH_NUL);
                seal_line();
            end
            PH_VAL_U:
            begin
                wr_ptr = trim_ptr;
                mem_put(CH_NUL);
                seal_line();
            end
            PH_VAL_AQ:
                seal_line();
            default:
                drop_line();
        endcase
        phase = PH_LINE;
    endfunction

    function automatic void clear_store();
        wr_ptr     = 0;
        commit_ptr = 0;
        trim_ptr   = 0;
        phase      = PH_LINE;
        tok_empty  = 1'b1;
        ovf        = 1'b0;
        wfail      = 1'b0;
    endfunction

    function automatic result_t tokenize_step(cmd_t c, logic [7:0] b, logic [11:0] a);
        result_t r;
        bit      beyond;
        r.rd   = 8'd0;
        beyond = 1'b0;
        wfail  = 1'b0;
        if (c == CMD_TEXT && b != CH_NUL)
        begin
            take_text(b);
            if (wfail)
            begin
                drop_line();
                phase = is_break(b) ? PH_LINE : PH_COMMENT;
            end
        end
        else if (c == CMD_TEXT || c == CMD_EOT)
        begin
            take_end();
            if (wfail)
            begin
                drop_line();
                phase = PH_LINE;
            end
        end
        else if (c == CMD_READ)
        begin
            n_reads++;
            if (a < commit_ptr)
                r.rd = shadow_mem[a];
            else
                beyond = 1'b1;
        end
        else
        begin
            n_clears++;
            clear_store();
        end
        if (wfail)
            n_full++;
        wfail = 1'b0;
        r.len = 13'(commit_ptr);
        r.st  = beyond ? ST_BEYOND : (ovf ? ST_OVERFLOW : ST_OK);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic add_word(cmd_t c, logic [7:0] t, logic [11:0] a, bit pk);
        in_word_t w;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        w.cmd   = c;
        w.text  = t;
        w.addr  = a;
        w.pick  = pk;
        w.drain = 1'b0;
        w.gap   = tx_calm ? 0 : $urandom_range(0, 19);
        text_feed.push_back(w);
        n_queued++;
    endtask

    task automatic add_drain();
        in_word_t w;
        w.cmd   = CMD_TEXT;
        w.text  = 8'd0;
        w.addr  = 12'd0;
        w.pick  = 1'b0;
        w.drain = 1'b1;
        w.gap   = 0;
        text_feed.push_back(w);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_word(CMD_TEXT, s[i], 12'($urandom), 1'b0);
    endtask

    task automatic send_line_buf();
        foreach (line_buf[i])
            add_word(CMD_TEXT, line_buf[i], 12'($urandom), 1'b0);
        line_buf.delete();
    endtask

    // Name byte: no blanks and nothing that starts or ends an item
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(128, 255));
        do
            b = 8'($urandom_range(33, 126));
        while (b == CH_EQUAL || b == CH_QUOTE || b == CH_BSLASH || b == CH_SEMI ||
               b == CH_LBRACK || b == CH_RBRACK);
        return b;
    endfunction

    task automatic put_blanks(int hi);
        repeat ($urandom_range(0, hi))
            line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic put_plain(int lo, int hi);
        repeat ($urandom_range(lo, hi))
            line_buf.push_back(($urandom_range(0, 7) == 0) ? CH_SPACE : plain_byte());
    endtask

    // Quoted token with backslash escapes of any nonzero byte
    task automatic put_quoted(int lo, int hi);
        line_buf.push_back(CH_QUOTE);
        repeat ($urandom_range(lo, hi))
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                line_buf.push_back(CH_BSLASH);
                line_buf.push_back(8'($urandom_range(1, 255)));
            end
            else
                line_buf.push_back(plain_byte());
        end
        line_buf.push_back(CH_QUOTE);
    endtask

    task automatic put_setting();
        if ($urandom_range(0, 3) == 0)
            put_quoted(1, 6);
        else
            put_plain(1, 8);
        put_blanks(2);
        line_buf.push_back(CH_EQUAL);
        put_blanks(2);
        case ($urandom_range(0, 5))
            0: ;
            1, 2: put_quoted(0, 10);
            default: put_plain(1, 12);
        endcase
        put_blanks(2);
    endtask

    task automatic put_section();
        line_buf.push_back(CH_LBRACK);
        repeat ($urandom_range(0, 8))
            line_buf.push_back(plain_byte());
        line_buf.push_back(CH_RBRACK);
    endtask

    // One line of text: mostly well formed, some broken, some noise
    task automatic gen_line();
        int kind;
        int keep;
        int ending;
        logic [7:0] b;
        put_blanks(2);
        kind = $urandom_range(0, 99);
        if (kind < 36)
            put_setting();
        else if (kind < 50)
        begin
            put_section();
            if ($urandom_range(0, 3) == 0)
                put_setting();
        end
        else if (kind < 58)
        begin
            line_buf.push_back(CH_SEMI);
            repeat ($urandom_range(0, 10))
            begin
                do
                    b = 8'($urandom_range(1, 255));
                while (is_break(b));
                line_buf.push_back(b);
            end
        end
        else if (kind < 63)
            ;
        else if (kind < 67)
        begin
            // empty key, plain or quoted
            if ($urandom_range(0, 1))
                line_buf.push_back(CH_EQUAL);
            else
            begin
                line_buf.push_back(CH_QUOTE);
                line_buf.push_back(CH_QUOTE);
                put_blanks(1);
                line_buf.push_back(CH_EQUAL);
            end
            put_plain(0, 4);
        end
        else if (kind < 71)
            put_plain(1, 8);
        else if (kind < 76)
        begin
            // junk after a closing quote, on the key or on the value
            if ($urandom_range(0, 1))
            begin
                put_quoted(1, 4);
                put_blanks(1);
                line_buf.push_back(plain_byte());
                put_setting();
            end
            else
            begin
                put_plain(1, 4);
                line_buf.push_back(CH_EQUAL);
                put_quoted(0, 4);
                put_blanks(1);
                put_plain(1, 3);
            end
        end
        else if (kind < 81)
        begin
            // quote left open until the line break
            if ($urandom_range(0, 1))
            begin
                put_plain(1, 4);
                line_buf.push_back(CH_EQUAL);
            end
            line_buf.push_back(CH_QUOTE);
            put_plain(0, 6);
        end
        else if (kind < 85)
        begin
            line_buf.push_back(CH_LBRACK);
            put_plain(0, 6);
        end
        else if (kind < 92)
        begin
            repeat ($urandom_range(1, 8))
                line_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
            put_setting();

        // Cut some lines short with end of text
        if (line_buf.size() > 1 && $urandom_range(0, 9) == 0)
        begin
            keep = $urandom_range(1, line_buf.size() - 1);
            while (line_buf.size() > keep)
                void'(line_buf.pop_back());
            ending = 90;
        end
        else
            ending = $urandom_range(0, 99);
        send_line_buf();
        if (ending < 45)
            add_word(CMD_TEXT, CH_LF, 12'($urandom), 1'b0);
        else if (ending < 70)
            add_text("\r\n");
        else if (ending < 85)
            add_word(CMD_TEXT, CH_CR, 12'($urandom), 1'b0);
        else if (ending < 95)
            add_word(CMD_EOT, 8'($urandom), 12'($urandom), 1'b0);
        else
            add_word(CMD_TEXT, CH_NUL, 12'($urandom), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Driver: one word per handshake, random gap before each
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        in_word_t cur;
        bit       nv;
        if (rst_n && (in_taken || !s_tvalid))
        begin
            nv = 1'b0;
            if (tx_wait > 0)
                tx_wait--;
            else if (text_feed.size() > 0)
            begin
                if (text_feed[0].drain)
                begin
                    // hold off until every result is back
                    if (predicted_out.size() == 0)
                        void'(text_feed.pop_front());
                end
                else
                begin
                    cur = text_feed.pop_front();
                    if (cur.pick)
                        cur.addr = (commit_ptr == 0) ? 12'($urandom_range(0, 4095))
                                                     : 12'($urandom_range(0, commit_ptr - 1));
                    s_tdata <= {4'd0, cur.addr, cur.text};
                    s_tuser <= cur.cmd;
                    tx_wait  = cur.gap;
                    nv       = 1'b1;
                end
            end
            s_tvalid <= nv;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall before each result word
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 19);
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input handshakes, check on output handshakes
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(string what, logic [12:0] want_v, logic [12:0] got_v);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want_v, got_v);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        n_cycles++;
        in_taken  = rst_n && s_tvalid && s_tready;
        out_taken = rst_n && m_tvalid && m_tready;
        if (in_taken)
        begin
            predicted_out.push_back(tokenize_step(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[19:8]));
            n_words++;
        end
        if (out_taken)
        begin
            if (predicted_out.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: result word 0x%0h with nothing expected", $time, m_tdata);
            end
            else
            begin
                want = predicted_out.pop_front();
                n_checked++;
                if (m_tdata[7:0] !== want.rd)
                    flag_mismatch("read_byte", 13'(want.rd), 13'(m_tdata[7:0]));
                if (m_tdata[20:8] !== want.len)
                    flag_mismatch("stored_length", want.len, m_tdata[20:8]);
                if (m_tdata[22:21] !== want.st)
                    flag_mismatch("status", 13'(want.st), 13'(m_tdata[22:21]));
            end
        end
    end

    // Stop a hung run
    initial
    begin
        while (n_cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("%0t: cycle limit reached with %0d results pending", $time,
                 predicted_out.size());
        $display("ini_text_tokenizer_core_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int filled;
        int len;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 24'd0;
        s_tuser  = CMD_TEXT;
        m_tready = 1'b0;
        clear_store();

        // Directed: empty-store read, section then setting on one line,
        // zero byte as end of text, empty key, break in a quoted key,
        // unfinished key at end of text, clear
        add_word(CMD_READ, 8'd0, 12'hFFF, 1'b0);
        add_text("[a]k=v");
        add_word(CMD_TEXT, CH_NUL, 12'd0, 1'b0);
        add_word(CMD_READ, 8'hFF, 12'd0, 1'b0);
        add_text(" =\n");
        add_text("\"x\n");
        add_word(CMD_TEXT, 8'hFF, 12'd0, 1'b0);
        add_word(CMD_EOT, 8'd0, 12'd0, 1'b0);
        add_word(CMD_READ, 8'd0, 12'd7, 1'b0);
        add_word(CMD_CLEAR, 8'd0, 12'd0, 1'b0);
        add_word(CMD_READ, 8'd0, 12'hFFF, 1'b0);
        add_drain();

        // Random text with reads, end-of-text words and rare clears
        while (n_queued < 1620)
        begin
            len = $urandom_range(0, 99);
            if (len < 12)
                add_word(CMD_READ, 8'($urandom), 12'($urandom), $urandom_range(0, 4) != 0);
            else if (len < 14)
                add_word(CMD_EOT, 8'($urandom), 12'($urandom), 1'b0);
            else if (len == 14 && $urandom_range(0, 7) == 0)
                add_word(CMD_CLEAR, 8'($urandom), 12'($urandom), 1'b0);
            else if (len == 15 && $urandom_range(0, 5) == 0)
                add_drain();
            else
                gen_line();
        end
        add_drain();

        // Fill the store close to its depth, then let random lines run over
        add_word(CMD_CLEAR, 8'd0, 12'd0, 1'b0);
        filled = 0;
        while (filled < STORE_DEPTH - 96)
        begin
            len = $urandom_range(30, 60);
            line_buf.push_back(plain_byte());
            line_buf.push_back(CH_EQUAL);
            repeat (len)
                line_buf.push_back(plain_byte());
            line_buf.push_back(CH_LF);
            send_line_buf();
            filled += len + 3;
        end
        repeat (60)
        begin
            gen_line();
            if ($urandom_range(0, 3) == 0)
                add_word(CMD_READ, 8'd0, 12'd0, 1'b1);
        end
        repeat (12)
            add_word(CMD_READ, 8'd0, 12'd0, 1'b1);
        add_word(CMD_READ, 8'd0, 12'hFFF, 1'b0);
        add_drain();
        add_word(CMD_CLEAR, 8'd0, 12'd0, 1'b0);
        repeat (6)
            gen_line();
        add_word(CMD_READ, 8'd0, 12'd0, 1'b1);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        while (text_feed.size() != 0 || s_tvalid || predicted_out.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d words (%0d reads, %0d clears), %0d results checked,",
                 n_words, n_reads, n_clears, n_checked);
        $display("%0d items committed, %0d words hit a full store, %0d mismatches",
                 n_seals, n_full, n_errors);
        if (n_errors == 0 && predicted_out.size() == 0)
            $display("ini_text_tokenizer_core_tb passed");
        else
            $display("ini_text_tokenizer_core_tb failed");
        $finish;
    end

endmodule
